// ===== rtl/omrt_pkg.sv =====
// ----------------------------------------------------------------------------
// omrt_pkg: shared types and constants of the motion onset reaction timer
// Payload structs, configuration set, register indexes and arm source codes.
// ----------------------------------------------------------------------------
`default_nettype none

package omrt_pkg;

  localparam int FORCE_BITS_DEFAULT = 12;
  localparam int FORCE_W            = 12;
  localparam int GYRO_W             = 16;
  localparam int SQ_W               = 31;  // (-32768)^2 = 2^30
  localparam int NUM_AXES           = 3;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 32;

  // arm source codes
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_GYRO  = 2'd1;
  localparam logic [1:0] SRC_FORCE = 2'd2;

  // reset values of the configuration registers
  localparam logic [31:0] GYRO_SQ_RST   = 32'd1000000;
  localparam logic [11:0] FORCE_THR_RST = 12'd2048;
  localparam logic [15:0] TIMEOUT_RST   = 16'd1000;
  localparam logic [9:0]  PERIOD_RST    = 10'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_SQ   = 2'd0,
    CFG_FORCE_THR = 2'd1,
    CFG_TIMEOUT   = 2'd2,
    CFG_PERIOD    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] gyro_onset_square;
    logic [11:0] force_threshold;
    logic [15:0] onset_timeout_ms;
    logic [9:0]  tick_period_ms;
  } cfg_t;

  typedef struct packed {
    logic                     is_force_down;
    logic                     is_force_up;
    logic signed [GYRO_W-1:0] gyro_x;
    logic signed [GYRO_W-1:0] gyro_y;
    logic signed [GYRO_W-1:0] gyro_z;
    logic [FORCE_W-1:0]       force_raw;
    logic [31:0]              tick_now;
    logic                     release_fired;
  } in_item_t;

  typedef struct packed {
    logic        measured;
    logic [31:0] reaction_ms;
    logic [1:0]  arm_source;
    logic [31:0] last_reaction_ms;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/omrt_sq_lane.sv =====
// ----------------------------------------------------------------------------
// omrt_sq_lane: one gyro axis squaring lane
// Squares a signed axis sample and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module omrt_sq_lane (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [omrt_pkg::GYRO_W-1:0] axis_i,
  output logic [omrt_pkg::SQ_W-1:0]               sq_o
);

  logic signed [2*omrt_pkg::GYRO_W-1:0] prod;
  logic [omrt_pkg::SQ_W-1:0]            sq_q;

  assign prod = axis_i * axis_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= prod[omrt_pkg::SQ_W-1:0];
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

// ===== rtl/omrt_core.sv =====
// ----------------------------------------------------------------------------
// omrt_core: merge stage and arm state
// Sums the lane squares, decides arm / timeout / cancel / measure, holds state.
// ----------------------------------------------------------------------------
`default_nettype none

module omrt_core #(
  parameter int FORCE_BITS = omrt_pkg::FORCE_BITS_DEFAULT
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire omrt_pkg::in_item_t        item_i,
  input  wire logic [omrt_pkg::SQ_W-1:0] sq_i [omrt_pkg::NUM_AXES],
  input  wire omrt_pkg::cfg_t            cfg_i,
  output omrt_pkg::out_item_t            res_o
);

  localparam int CMP_BITS = (FORCE_BITS < omrt_pkg::FORCE_W) ? FORCE_BITS : omrt_pkg::FORCE_W;

  logic        armed_q, armed_d;
  logic [31:0] onset_q, onset_d;
  logic [1:0]  src_q, src_d;
  logic        prev_up_q, prev_up_d;
  logic [31:0] last_q, last_d;

  logic [31:0] sq_sum;
  logic        gyro_hit, force_hit, arm_now;
  logic [31:0] diff;
  logic [41:0] age_full;
  logic [31:0] age;
  logic        armed1, armed3, tmo, mode_edge, meas;
  logic [1:0]  src1;

  assign sq_sum = 32'(sq_i[0]) + 32'(sq_i[1]) + 32'(sq_i[2]);
  assign gyro_hit  = sq_sum > cfg_i.gyro_onset_square;
  assign force_hit = item_i.force_raw[CMP_BITS-1:0] > cfg_i.force_threshold[CMP_BITS-1:0];
  assign arm_now   = item_i.is_force_down && !armed_q && (gyro_hit || force_hit);

  // fresh arm: onset is this tick, age is zero
  assign diff     = arm_now ? 32'd0 : (item_i.tick_now - onset_q);
  assign age_full = 42'(diff) * 42'(cfg_i.tick_period_ms);
  assign age      = age_full[31:0];

  always_comb begin
    armed1    = armed_q || arm_now;
    src1      = arm_now ? (gyro_hit ? omrt_pkg::SRC_GYRO : omrt_pkg::SRC_FORCE) : src_q;
    onset_d   = arm_now ? item_i.tick_now : onset_q;
    tmo       = armed1 && (age > 32'(cfg_i.onset_timeout_ms));
    mode_edge = prev_up_q && item_i.is_force_down;
    armed3    = armed1 && !tmo && !mode_edge;
    src_d     = (tmo || mode_edge) ? omrt_pkg::SRC_NONE : src1;
    prev_up_d = item_i.is_force_up;
    meas      = item_i.release_fired && armed3;
    armed_d   = armed3 && !meas;
    last_d    = meas ? age : last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      onset_q   <= '0;
      src_q     <= omrt_pkg::SRC_NONE;
      prev_up_q <= 1'b0;
      last_q    <= '0;
    end else if (en_i) begin
      armed_q   <= armed_d;
      onset_q   <= onset_d;
      src_q     <= src_d;
      prev_up_q <= prev_up_d;
      last_q    <= last_d;
    end
  end

  always_comb begin
    res_o.measured         = meas;
    res_o.reaction_ms      = meas ? age : 32'd0;
    res_o.arm_source       = src_d;
    res_o.last_reaction_ms = last_d;
  end

endmodule

`default_nettype wire

// ===== rtl/motion_onset_reaction_timer_unit.sv =====
// ----------------------------------------------------------------------------
// motion_onset_reaction_timer_unit: reaction time from motion onset to release
// Path: a transfer is registered in the square lanes, then merged and registered in the output register.
// Throughput: one transfer per cycle while the result channel is not stalled; the arm state closes in the merge stage.
// Reset: asynchronous, active low; clears arm state, pipeline valids and
// loads the configuration register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_onset_reaction_timer_unit #(
  parameter int FORCE_BITS = omrt_pkg::FORCE_BITS_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // config write port
  input  wire logic                            cfg_we_i,
  input  wire logic [omrt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [omrt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // sample channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire omrt_pkg::in_item_t              in_item_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output omrt_pkg::out_item_t                  out_item_o
);

  // Configuration registers
  omrt_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gyro_onset_square <= omrt_pkg::GYRO_SQ_RST;
      cfg_q.force_threshold   <= omrt_pkg::FORCE_THR_RST;
      cfg_q.onset_timeout_ms  <= omrt_pkg::TIMEOUT_RST;
      cfg_q.tick_period_ms    <= omrt_pkg::PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        omrt_pkg::CFG_GYRO_SQ:   cfg_q.gyro_onset_square <= cfg_wdata_i;
        omrt_pkg::CFG_FORCE_THR: cfg_q.force_threshold   <= cfg_wdata_i[11:0];
        omrt_pkg::CFG_TIMEOUT:   cfg_q.onset_timeout_ms  <= cfg_wdata_i[15:0];
        omrt_pkg::CFG_PERIOD:    cfg_q.tick_period_ms    <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: stage 1 = square lanes, stage 2 = output register.
  // A stage takes a new transfer when empty or when it drains this cycle.
  logic s1_v_q, out_v_q;
  logic out_ready, s1_ready, in_acc, adv;

  assign out_ready  = !out_v_q || !out_stall_i;
  assign s1_ready   = !s1_v_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;
  assign adv        = s1_v_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_valid_i;
      end
      if (out_ready) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  // Stage 1: sample fields held alongside the lane squares
  omrt_pkg::in_item_t s1_item_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
    end
  end

  // Square lanes, one per gyro axis
  logic signed [omrt_pkg::GYRO_W-1:0] axis [omrt_pkg::NUM_AXES];
  logic [omrt_pkg::SQ_W-1:0]          sq   [omrt_pkg::NUM_AXES];

  assign axis[0] = in_item_i.gyro_x;
  assign axis[1] = in_item_i.gyro_y;
  assign axis[2] = in_item_i.gyro_z;

  for (genvar g = 0; g < omrt_pkg::NUM_AXES; g++) begin : g_lane
    omrt_sq_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (in_acc),
      .axis_i (axis[g]),
      .sq_o   (sq[g])
    );
  end

  // Merge stage: threshold compares, arm state, elapsed time
  omrt_pkg::out_item_t res;

  omrt_core #(
    .FORCE_BITS (FORCE_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (s1_item_q),
    .sq_i   (sq),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Output register
  omrt_pkg::out_item_t out_item_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_item_q;

  // Assertions
  a_meas_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.measured) |-> (out_item_o.arm_source != omrt_pkg::SRC_NONE))
    else $error("measurement reported without an arm source");

  a_meas_updates_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.measured) |->
      (out_item_o.reaction_ms == out_item_o.last_reaction_ms))
    else $error("last reaction time not updated by measurement");

  a_idle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.measured) |-> (out_item_o.reaction_ms == 32'd0))
    else $error("reaction time nonzero without measurement");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_v_q))
    else $error("input stalled while pipeline can advance");

endmodule

`default_nettype wire
